// ===== rtl/qws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qws_pkg;

    // Byte codes the splitter treats specially.
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // Kind of one result.
    localparam logic KIND_BYTE     = 1'b0;
    localparam logic KIND_END_WORD = 1'b1;

    // Most results a single input byte can cause.
    localparam int MAX_RESULTS = 4;
    localparam int SLOT_W      = $clog2(MAX_RESULTS);
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_DOUBLE = 2'd1,
        QM_SINGLE = 2'd2
    } quote_mode_t;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        logic        word_open;
        quote_mode_t quote_mode;
        logic        escape_pending;
        logic        separator_seen;
    } split_state_t;

    localparam split_state_t STATE_RESET = '{
        word_open:      1'b0,
        quote_mode:     QM_NONE,
        escape_pending: 1'b0,
        separator_seen: 1'b0
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] word_byte;
    } result_t;

    // All results of one input byte, in order, with their count.
    typedef struct packed {
        logic [COUNT_W-1:0]           count;
        result_t [MAX_RESULTS-1:0]    slot;
    } result_bundle_t;

endpackage

`default_nettype wire

// ===== rtl/qws_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qws_step (
    input  qws_pkg::split_state_t   state_in,
    input  logic [7:0]              ch,
    input  logic                    end_of_text,
    output qws_pkg::split_state_t   state_out,
    output qws_pkg::result_bundle_t bundle
);
    import qws_pkg::*;

    logic                    blank;
    logic                    take;
    logic                    bare;
    logic [MAX_RESULTS-1:0]  cand_valid;
    result_t [MAX_RESULTS-1:0] cand;
    split_state_t            st;

    // Whitespace: space, or tab through carriage return.
    assign blank = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign take  = state_in.escape_pending || (state_in.quote_mode != QM_NONE) || !blank;
    assign bare  = (ch == CH_BACKSLASH) || (ch == CH_DQUOTE) || (ch == CH_SQUOTE) ||
                   (ch == CH_SPACE);

    // Work out the candidate results and the state after this byte.
    always_comb begin
        st         = state_in;
        cand_valid = '0;
        cand[0]    = '{kind: KIND_END_WORD, word_byte: 8'h00};
        cand[1]    = '{kind: KIND_BYTE, word_byte: CH_BACKSLASH};
        cand[2]    = '{kind: KIND_BYTE, word_byte: ch};
        cand[3]    = '{kind: KIND_END_WORD, word_byte: 8'h00};
        if (!take) begin
            if (state_in.word_open) begin
                st.separator_seen = 1'b1;
            end
        end else begin
            // An owed end mark goes out before the new word starts.
            cand_valid[0]     = state_in.separator_seen;
            st.separator_seen = 1'b0;
            st.word_open      = 1'b1;
            if (state_in.escape_pending) begin
                cand_valid[1]     = !bare;
                cand_valid[2]     = 1'b1;
                st.escape_pending = 1'b0;
            end else if (ch == CH_BACKSLASH) begin
                st.escape_pending = 1'b1;
            end else if ((ch == CH_DQUOTE) && (state_in.quote_mode != QM_SINGLE)) begin
                st.quote_mode = (state_in.quote_mode == QM_NONE) ? QM_DOUBLE : QM_NONE;
            end else if ((ch == CH_SQUOTE) && (state_in.quote_mode != QM_DOUBLE)) begin
                st.quote_mode = (state_in.quote_mode == QM_NONE) ? QM_SINGLE : QM_NONE;
            end else begin
                cand_valid[2] = 1'b1;
            end
        end
        // End of text closes an open word and returns to reset.
        if (end_of_text) begin
            cand_valid[3] = st.word_open;
            st            = STATE_RESET;
        end
    end

    assign state_out = st;

    // Pack the valid candidates into consecutive slots.
    always_comb begin
        logic [COUNT_W-1:0] n;
        n           = '0;
        bundle.slot = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (cand_valid[i]) begin
                bundle.slot[n[SLOT_W-1:0]] = cand[i];
                n = n + 1'b1;
            end
        end
        bundle.count = n;
    end

endmodule

`default_nettype wire

// ===== rtl/quoted_word_splitter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Quoted word splitter: one text byte per request in, word bytes and end marks out.
// The first result of a byte appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle while m_tready is high; a byte causing N results
// holds the input until the single result register has drained them, one per cycle.
// Reset (aresetn low, synchronous) returns the parser to the unquoted, no-word state
// and empties the result register.

module quoted_word_splitter_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Input requests.
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] ch
    input  wire logic       s_tlast,   // end_of_text
    // Result requests.
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] word_byte
    output logic            m_tuser,   // [0] kind
    output logic            m_tlast    // last_of_run
);
    import qws_pkg::*;

    split_state_t      state_reg;
    split_state_t      state_next;
    result_bundle_t    step_bundle;
    result_t [MAX_RESULTS-1:0] slot_reg;
    result_t [MAX_RESULTS-1:0] slot_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic              s_accept;
    logic              m_accept;

    qws_step u_step (
        .state_in    (state_reg),
        .ch          (s_tdata),
        .end_of_text (s_tlast),
        .state_out   (state_next),
        .bundle      (step_bundle)
    );

    assign m_accept = m_tvalid && m_tready;
    // Room for a new byte once the results held are gone or the last one leaves now.
    assign s_tready = (count_reg == '0) ||
                      ((count_reg == COUNT_W'(1)) && m_tready);
    assign s_accept = s_tvalid && s_tready;

    // Result register: load a new bundle, or shift out the front result.
    always_comb begin
        slot_next  = slot_reg;
        count_next = count_reg;
        if (m_accept) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                slot_next[i] = slot_reg[i + 1];
            end
            count_next = count_reg - 1'b1;
        end
        if (s_accept && (step_bundle.count != '0)) begin
            slot_next  = step_bundle.slot;
            count_next = step_bundle.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
            count_reg <= '0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = slot_reg[0].word_byte;
    assign m_tuser  = slot_reg[0].kind;
    assign m_tlast  = (count_reg == COUNT_W'(1));

endmodule

`default_nettype wire
